@@ hdl/spt_pkg.sv @@
// shared types and constants for the scanline span table
package spt_pkg;

  localparam int COL_W = 9;

  localparam logic OP_EDGE  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // classified item handed from the front end to the back end
  typedef struct packed {
    logic             is_query;
    logic             clear_first;
    logic [COL_W-1:0] x_start;
    logic [COL_W-1:0] y_start;
    logic [COL_W-1:0] y_stop;
    logic             dx_neg;
    logic [COL_W-1:0] dx_mag;
    logic [COL_W-1:0] dy;
    logic [COL_W-1:0] query_row;
  } cmd_t;

  typedef struct packed {
    logic init_done;
    logic out_load;
  } bk_status_t;

endpackage

@@ hdl/spt_in_if.sv @@
// input channel: edge and query beats
interface spt_in_if;
  import spt_pkg::*;
  logic             valid;
  logic             ready;
  logic             operation;
  logic             clear_first;
  logic [COL_W-1:0] start_x;
  logic [COL_W-1:0] start_y;
  logic [COL_W-1:0] end_x;
  logic [COL_W-1:0] end_y;
  logic [COL_W-1:0] query_row;

  modport source (output valid, operation, clear_first, start_x, start_y, end_x, end_y,
                  query_row, input ready);
  modport sink (input valid, operation, clear_first, start_x, start_y, end_x, end_y,
                query_row, output ready);
endinterface

@@ hdl/spt_out_if.sv @@
// output channel: span beats
interface spt_out_if;
  import spt_pkg::*;
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] span_row;
  logic [COL_W-1:0] span_left;
  logic [COL_W-1:0] span_right;
  logic             row_filled;

  modport source (output valid, span_row, span_left, span_right, row_filled, input ready);
  modport sink (input valid, span_row, span_left, span_right, row_filled, output ready);
endinterface

@@ hdl/spt_ram.sv @@
// generic simple dual port ram with registered read
module spt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

@@ hdl/spt_fifo.sv @@
// two entry command queue between front and back
module spt_fifo import spt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  input  logic pop,
  output cmd_t pop_data,
  output logic full,
  output logic empty
);
  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end
endmodule

@@ hdl/spt_front.sv @@
// front end: accepts beats, orders endpoints, forms edge deltas
module spt_front import spt_pkg::*; (
  spt_in_if.sink   cmd,
  input  logic     queue_full,
  input  logic     init_done,
  output logic     push,
  output cmd_t     push_data
);
  logic             swap;
  logic [COL_W-1:0] xa, ya, xb, yb;
  logic [COL_W:0]   dx;

  assign cmd.ready = !queue_full && init_done;
  assign push      = cmd.valid && cmd.ready;

  always_comb begin
    swap = cmd.start_y > cmd.end_y;
    xa   = swap ? cmd.end_x   : cmd.start_x;
    ya   = swap ? cmd.end_y   : cmd.start_y;
    xb   = swap ? cmd.start_x : cmd.end_x;
    yb   = swap ? cmd.start_y : cmd.end_y;
    dx   = {1'b0, xb} - {1'b0, xa};

    push_data.is_query    = (cmd.operation == OP_QUERY);
    push_data.clear_first = cmd.clear_first;
    push_data.x_start     = xa;
    push_data.y_start     = ya;
    push_data.y_stop      = yb;
    push_data.dx_neg      = dx[COL_W];
    push_data.dx_mag      = dx[COL_W] ? COL_W'(~dx + 1'b1) : dx[COL_W-1:0];
    push_data.dy          = yb - ya;
    push_data.query_row   = cmd.query_row;
  end
endmodule

@@ hdl/spt_back.sv @@
// back end: table sweep, slope divider, row walker and query port
module spt_back import spt_pkg::*; #(
  parameter int ROWS          = 512,
  parameter int FRACTION_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       queue_empty,
  input  cmd_t       queue_data,
  output logic       pop,
  output bk_status_t status,
  spt_out_if.source  span
);
  localparam int RW = $clog2(ROWS);
  localparam int QW = COL_W + FRACTION_BITS;
  localparam int AW = QW + 1;
  localparam int CW = $clog2(QW + 1);
  localparam int EW = 1 + 2 * COL_W;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_CLEAR, S_SETUP, S_DIV, S_SIGN, S_WALK, S_QWAIT
  } state_t;

  state_t             state;
  cmd_t               cur;
  logic [RW-1:0]      sweep_idx;
  logic [COL_W-1:0]   rem;
  logic [QW-1:0]      quo;
  logic [CW-1:0]      div_cnt;
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] slope;
  logic [COL_W-1:0]   row_y;
  logic               p_valid;
  logic [RW-1:0]      p_row;
  logic [COL_W-1:0]   p_col;
  logic               q_hit;
  logic               init_done;
  logic               out_valid;
  logic [COL_W-1:0]   out_row, out_left, out_right;
  logic               out_filled;

  logic               we, re;
  logic [RW-1:0]      waddr, raddr;
  logic [EW-1:0]      wdata, rdata;
  logic [COL_W:0]     trial;
  logic               fits;
  logic [COL_W-1:0]   col_now;
  logic               row_in, qrow_in;
  logic               take_query, take_edge;
  logic [COL_W-1:0]   old_left, old_right;

  spt_ram #(.WIDTH(EW), .DEPTH(ROWS)) u_table (
    .clk, .we, .waddr, .wdata, .re, .raddr, .rdata
  );

  assign old_left  = rdata[2*COL_W-1:COL_W];
  assign old_right = rdata[COL_W-1:0];

  always_comb begin
    trial      = {rem, quo[QW-1]};
    fits       = trial >= {1'b0, cur.dy};
    col_now    = acc[AW-1] ? '0 : acc[QW-1:FRACTION_BITS];
    row_in     = int'(row_y) < ROWS;
    qrow_in    = int'(queue_data.query_row) < ROWS;
    // a query waits while the last walked row is still being written or an earlier span is still held
    take_query = (state == S_IDLE) && !queue_empty && queue_data.is_query && !out_valid &&
                 !p_valid;
    take_edge  = (state == S_IDLE) && !queue_empty && !queue_data.is_query;
    pop        = take_query || take_edge;

    re    = 1'b0;
    raddr = RW'(row_y);
    if (state == S_WALK) begin
      re = row_in;
    end else if (take_query) begin
      re    = qrow_in;
      raddr = RW'(queue_data.query_row);
    end

    we    = 1'b0;
    waddr = p_row;
    wdata = '0;
    if (state == S_INIT || state == S_CLEAR) begin
      we    = 1'b1;
      waddr = sweep_idx;
    end else if (p_valid) begin
      // first touch loads both columns, later touches fold min and max
      we = 1'b1;
      if (!rdata[EW-1]) begin
        wdata = {1'b1, p_col, p_col};
      end else begin
        wdata = {1'b1, (p_col < old_left) ? p_col : old_left,
                 (p_col > old_right) ? p_col : old_right};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      sweep_idx <= '0;
      init_done <= 1'b0;
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      p_valid <= 1'b0;
      if (span.valid && span.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          sweep_idx <= sweep_idx + 1'b1;
          if (sweep_idx == RW'(ROWS - 1)) begin
            init_done <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (take_edge) begin
            cur       <= queue_data;
            sweep_idx <= '0;
            state     <= queue_data.clear_first ? S_CLEAR : S_SETUP;
          end else if (take_query) begin
            cur   <= queue_data;
            q_hit <= qrow_in;
            state <= S_QWAIT;
          end
        end
        S_CLEAR: begin
          sweep_idx <= sweep_idx + 1'b1;
          if (sweep_idx == RW'(ROWS - 1)) begin
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          rem     <= '0;
          quo     <= {cur.dx_mag, {FRACTION_BITS{1'b0}}};
          div_cnt <= '0;
          acc     <= {1'b0, cur.x_start, {FRACTION_BITS{1'b0}}};
          row_y   <= cur.y_start;
          slope   <= '0;
          state   <= (cur.dy == '0) ? S_WALK : S_DIV;
        end
        S_DIV: begin
          // one quotient bit per cycle, restoring
          rem     <= fits ? COL_W'(trial - {1'b0, cur.dy}) : trial[COL_W-1:0];
          quo     <= {quo[QW-2:0], fits};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == CW'(QW - 1)) begin
            state <= S_SIGN;
          end
        end
        S_SIGN: begin
          slope <= cur.dx_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
          state <= S_WALK;
        end
        S_WALK: begin
          p_valid <= row_in;
          p_row   <= RW'(row_y);
          p_col   <= col_now;
          acc     <= acc + slope;
          row_y   <= row_y + 1'b1;
          if (row_y == cur.y_stop) begin
            state <= S_IDLE;
          end
        end
        S_QWAIT: begin
          out_valid  <= 1'b1;
          out_row    <= cur.query_row;
          out_filled <= q_hit && rdata[EW-1];
          out_left   <= (q_hit && rdata[EW-1]) ? old_left : '0;
          out_right  <= (q_hit && rdata[EW-1]) ? old_right : '0;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign status.init_done = init_done;
  assign status.out_load  = (state == S_QWAIT);

  assign span.valid      = out_valid;
  assign span.span_row   = out_row;
  assign span.span_left  = out_left;
  assign span.span_right = out_right;
  assign span.row_filled = out_filled;
endmodule

@@ hdl/scanline_polygon_span_table_core.sv @@
// a query beat's span is read from the span table and registered for output
// an edge runs the bit-serial slope divider (skipped for a horizontal edge), then walks
// one table row per cycle from its low to its high endpoint
// clear_first adds a sweep over all ROWS rows of the span table before the walk
// reset runs the same sweep; no beat is accepted until it ends
module scanline_polygon_span_table_core import spt_pkg::*; #(
  parameter int ROWS          = 512,
  parameter int FRACTION_BITS = 16
) (
  input logic       clk,
  input logic       rst,
  spt_in_if.sink    cmd,
  spt_out_if.source span
);
  // classified commands waiting for the back end
  logic       push, pop, queue_full, queue_empty;
  cmd_t       push_data, pop_data;
  bk_status_t status;

  // front end orders endpoints so the walk always runs downward
  spt_front u_front (
    .cmd,
    .queue_full,
    .init_done (status.init_done),
    .push,
    .push_data
  );

  // short queue lets the front keep taking beats while the back walks
  spt_fifo u_queue (
    .clk, .rst,
    .push, .push_data,
    .pop, .pop_data,
    .full (queue_full),
    .empty (queue_empty)
  );

  // back end owns the span table, the divider and the output register
  spt_back #(.ROWS(ROWS), .FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk, .rst,
    .queue_empty,
    .queue_data (pop_data),
    .pop,
    .status,
    .span
  );

  // queue never takes a beat it has no room for
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !queue_full) else $error("command queue overflow");

  // a new span never overwrites one still waiting downstream
  a_no_clobber: assert property (@(posedge clk) disable iff (rst)
    status.out_load |-> !span.valid || span.ready) else $error("span register overwritten");

  // reset restarts the table sweep
  a_init_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !status.init_done) else $error("table ready right after reset");
endmodule

@@ dv/spt_span_checker.sv @@
// span checker: predicts each query beat's span from the edge beats and compares
module spt_span_checker import spt_pkg::*; #(
  parameter int ROWS          = 512,
  parameter int FRACTION_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  spt_in_if.sink   cmd_mon,
  spt_out_if.sink  span_mon,
  output int       fail_count,
  output int       spans_pending
);

  typedef struct packed {
    logic [COL_W-1:0] row;
    logic [COL_W-1:0] left;
    logic [COL_W-1:0] right;
    logic             filled;
  } span_t;

  logic [COL_W-1:0] min_col [ROWS];
  logic [COL_W-1:0] max_col [ROWS];
  logic             touched [ROWS];
  span_t            span_queue [$];

  assign spans_pending = span_queue.size();

  function automatic logic [COL_W-1:0] trunc_col(longint acc);
    longint c;
    if (acc < 0) return '0;
    c = acc >>> FRACTION_BITS;
    if (c > 511) c = 511;
    return c[COL_W-1:0];
  endfunction

  task automatic fold_col(int row, logic [COL_W-1:0] col);
    if (row >= ROWS) return;
    if (!touched[row]) begin
      touched[row] = 1'b1;
      min_col[row] = col;
      max_col[row] = col;
    end else begin
      if (col < min_col[row]) min_col[row] = col;
      if (col > max_col[row]) max_col[row] = col;
    end
  endtask

  task automatic trace_edge(int xa, int ya, int xb, int yb);
    longint slope, acc;
    int t;
    slope = 0;
    if (ya > yb) begin
      t = xa; xa = xb; xb = t;
      t = ya; ya = yb; yb = t;
    end
    if (yb != ya) slope = (longint'(xb - xa) <<< FRACTION_BITS) / longint'(yb - ya);
    acc = longint'(xa) <<< FRACTION_BITS;
    for (int y = ya; y <= yb; y++) begin
      fold_col(y, trunc_col(acc));
      acc += slope;
    end
  endtask

  always @(posedge clk) begin
    span_t got, want;
    if (rst) begin
      foreach (touched[i]) touched[i] = 1'b0;
      span_queue.delete();
      fail_count <= 0;
    end else begin
      if (cmd_mon.valid && cmd_mon.ready) begin
        if (cmd_mon.operation == OP_EDGE) begin
          if (cmd_mon.clear_first) foreach (touched[i]) touched[i] = 1'b0;
          trace_edge(cmd_mon.start_x, cmd_mon.start_y, cmd_mon.end_x, cmd_mon.end_y);
        end else begin
          want.row = cmd_mon.query_row;
          if (cmd_mon.query_row < ROWS && touched[cmd_mon.query_row]) begin
            want.left = min_col[cmd_mon.query_row];
            want.right = max_col[cmd_mon.query_row];
            want.filled = 1'b1;
          end else begin
            want.left = '0;
            want.right = '0;
            want.filled = 1'b0;
          end
          span_queue.push_back(want);
        end
      end
      if (span_mon.valid && span_mon.ready) begin
        got = '{span_mon.span_row, span_mon.span_left, span_mon.span_right,
                span_mon.row_filled};
        if (span_queue.size() == 0) begin
          $error("span beat with nothing expected: row %0d", got.row);
          fail_count <= fail_count + 1;
        end else begin
          want = span_queue.pop_front();
          if (got != want) begin
            if (got.row != want.row)
              $error("span_row expected %0d got %0d", want.row, got.row);
            if (got.left != want.left)
              $error("span_left expected %0d got %0d", want.left, got.left);
            if (got.right != want.right)
              $error("span_right expected %0d got %0d", want.right, got.right);
            if (got.filled != want.filled)
              $error("row_filled expected %0d got %0d", want.filled, got.filled);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

@@ dv/testbench.sv @@
// top of the span table testbench: stimulus, receiver stalls, verdict
module testbench;
  import spt_pkg::*;

  localparam int LIMIT = 20000;   // idle cycles tolerated

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   spans_pending;
  int   quiet_cycles = 0;
  bit   stall_free = 1'b0;   // calm stretch: no idling on either side
  bit   hold_off = 1'b0;     // long receiver stall

  spt_in_if  cmd_ch ();
  spt_out_if span_ch ();

  scanline_polygon_span_table_core u_top (
    .clk (clk), .rst (rst), .cmd (cmd_ch.sink), .span (span_ch.source)
  );

  spt_span_checker u_check (
    .clk (clk), .rst (rst), .cmd_mon (cmd_ch.sink), .span_mon (span_ch.sink),
    .fail_count (fail_count), .spans_pending (spans_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog: counts cycles where no beat moves on either channel
  always @(posedge clk) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (span_ch.valid && span_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random stalls, none during the calm stretch, all during a hold-off
  initial begin
    span_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      span_ch.ready <= !hold_off && (stall_free || $urandom_range(99) >= 21);
    end
  end

  // one long receiver hold-off while the sender keeps feeding queries
  initial begin
    @(negedge rst);
    repeat (3000) @(posedge clk);
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  end

  task automatic send_beat(logic op, logic clr, int sx, int sy, int ex, int ey, int qr);
    while (!stall_free && $urandom_range(99) < 21) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.operation   <= op;
    cmd_ch.clear_first <= clr;
    cmd_ch.start_x     <= COL_W'(sx);
    cmd_ch.start_y     <= COL_W'(sy);
    cmd_ch.end_x       <= COL_W'(ex);
    cmd_ch.end_y       <= COL_W'(ey);
    cmd_ch.query_row   <= COL_W'(qr);
    do @(posedge clk); while (!cmd_ch.ready);
    @(negedge clk);
  endtask

  task automatic add_edge(logic clr, int sx, int sy, int ex, int ey);
    send_beat(OP_EDGE, clr, sx, sy, ex, ey, $urandom_range(511));
  endtask

  task automatic ask_row(int qr);
    send_beat(OP_QUERY, 1'($urandom_range(1)), $urandom_range(511), $urandom_range(511),
              $urandom_range(511), $urandom_range(511), qr);
  endtask

  // short edges keep the run quick; a few can span up to the whole table
  function automatic int pick_dy();
    return ($urandom_range(99) < 3) ? $urandom_range(511) : $urandom_range(12);
  endfunction

  initial begin
    int y0, y1, x0, x1, q;
    cmd_ch.valid = 1'b0;
    cmd_ch.operation = OP_EDGE;
    cmd_ch.clear_first = 1'b0;
    cmd_ch.start_x = '0;
    cmd_ch.start_y = '0;
    cmd_ch.end_x = '0;
    cmd_ch.end_y = '0;
    cmd_ch.query_row = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: untouched rows, extremes, horizontal, swapped ends, clears
    ask_row(0);
    ask_row(511);
    add_edge(1'b0, 0, 0, 511, 511);      // full diagonal
    ask_row(0);
    ask_row(255);
    ask_row(511);
    add_edge(1'b0, 511, 511, 0, 0);      // same edge with endpoints swapped
    ask_row(300);
    add_edge(1'b0, 100, 40, 7, 40);      // horizontal: only the first column
    ask_row(40);
    add_edge(1'b0, 0, 20, 511, 10);      // low y second, steep negative slope
    ask_row(10);
    ask_row(15);
    add_edge(1'b1, 50, 5, 60, 9);        // clear first
    ask_row(5);
    ask_row(100);
    add_edge(1'b0, 511, 200, 511, 201);
    add_edge(1'b0, 3, 200, 3, 200);
    ask_row(200);
    ask_row(201);
    add_edge(1'b1, 0, 511, 0, 511);
    ask_row(511);

    // random: polygons built from connected edges around a band of rows, then queries
    for (int n = 0; n < 1110; ) begin
      if (n > 300 && n < 500) stall_free = 1'b1;
      else stall_free = 1'b0;
      y0 = $urandom_range(511);
      x0 = $urandom_range(511);
      if ($urandom_range(99) < 85) begin
        for (int k = $urandom_range(4, 1); k > 0; k--) begin
          y1 = y0 + pick_dy();
          if (y1 > 511 || $urandom_range(1)) y1 = (y0 >= 12) ? y0 - pick_dy() : y0;
          if (y1 < 0) y1 = 0;
          if (y1 > 511) y1 = 511;
          x1 = $urandom_range(511);
          add_edge(k == 1 && $urandom_range(99) < 15, x0, y0, x1, y1);
          n++;
          x0 = x1;
          y0 = y1;
        end
        for (int k = $urandom_range(6, 1); k > 0; k--) begin
          q = y0 + $urandom_range(12) - 6;
          if (q < 0 || q > 511 || $urandom_range(9) == 0) q = $urandom_range(511);
          ask_row(q);
          n++;
        end
      end else begin
        if ($urandom_range(1)) ask_row($urandom_range(511));
        else add_edge($urandom_range(99) < 5, x0, y0, $urandom_range(511),
                      (y0 + pick_dy()) % 512);
        n++;
      end
    end
    stall_free = 1'b0;
    cmd_ch.valid <= 1'b0;

    while (spans_pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
